// ===== rtl/core/rtph264_pkg.sv =====
// ----------------------------------------------------------------------------
// rtph264_pkg
// Types and constants shared by the RTP H.264 NAL reassembler.
// ----------------------------------------------------------------------------
package rtph264_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int POS_W        = 4;
  localparam logic [POS_W-1:0] POS_HEADER_END = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_SATURATE   = POS_W'(HEADER_BYTES + 2);

  localparam logic [1:0] RTP_VERSION   = 2'd2;
  localparam logic [4:0] NAL_TYPE_MIN  = 5'd1;
  localparam logic [4:0] NAL_TYPE_MAX  = 5'd23;
  localparam logic [4:0] FU_A_TYPE     = 5'd28;
  localparam logic [7:0] START_CODE_LO = 8'h00;
  localparam logic [7:0] START_CODE_HI = 8'h01;

  localparam logic [6:0] PAYLOAD_TYPE_RESET = 7'd96;

  // Register indexes on the configuration port.
  localparam logic REG_PAYLOAD_TYPE = 1'b0;

  // Depth of the burst queue between parser and output.
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Position of an output item inside one burst.
  localparam logic [2:0] PH_SC_FIRST = 3'd0;
  localparam logic [2:0] PH_SC_LAST  = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_STATUS   = 3'd5;

  // FU-A fragment position inside the current packet.
  localparam logic [1:0] FP_AWAIT  = 2'd0;
  localparam logic [1:0] FP_START  = 2'd1;
  localparam logic [1:0] FP_MIDDLE = 2'd2;
  localparam logic [1:0] FP_END    = 2'd3;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_DISCARD = 2'd1,
    MODE_SINGLE  = 2'd2,
    MODE_FUA     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_COMPLETE    = 3'd0,
    ST_FRAGMENT    = 3'd1,
    ST_TOO_SHORT   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_TYPE    = 3'd4,
    ST_START_END   = 3'd5,
    ST_NO_START    = 3'd6,
    ST_UNSUPPORTED = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
  } pkt_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] nal_byte;
    logic       nal_done;
    logic [2:0] status_code;
    logic       run_last;
  } res_item_t;

  // Everything one packet byte produces: optional start code, optional data
  // byte and optional status item, in that order.
  typedef struct packed {
    logic       has_start;
    logic       has_data;
    logic [7:0] data;
    logic       done;
    logic       has_status;
    status_t    code;
  } burst_t;

endpackage

// ===== rtl/core/rtph264_parse.sv =====
// ----------------------------------------------------------------------------
// rtph264_parse
// Per-byte RTP header check and FU-A state tracking; one burst per beat.
// ----------------------------------------------------------------------------
module rtph264_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  rtph264_pkg::pkt_item_t pkt,
  input  logic [6:0]             expected_pt,
  output logic                   push,
  output rtph264_pkg::burst_t    burst
);
  import rtph264_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  mode_t            packet_mode, packet_mode_next;
  status_t          pending_status, pending_status_next;
  logic             assembly_active, assembly_active_next;
  logic [2:0]       indicator_bits, indicator_bits_next;
  logic [1:0]       fragment_position, fragment_position_next;

  logic [7:0] b;
  logic       pend;
  logic [4:0] nal_type;

  assign b        = pkt.packet_byte;
  assign pend     = pkt.packet_end;
  assign nal_type = b[4:0];

  always_comb begin
    byte_position_next     = byte_position;
    packet_mode_next       = packet_mode;
    pending_status_next    = pending_status;
    assembly_active_next   = assembly_active;
    indicator_bits_next    = indicator_bits;
    fragment_position_next = fragment_position;
    burst                  = '0;
    burst.data             = b;

    if (byte_position < POS_HEADER_END) begin
      if (byte_position == POS_W'(0) && b[7:6] != RTP_VERSION) begin
        pending_status_next = ST_BAD_VERSION;
      end
      if (byte_position == POS_W'(1) && pending_status == ST_COMPLETE &&
          b[6:0] != expected_pt) begin
        pending_status_next = ST_BAD_TYPE;
      end
    end else if (byte_position == POS_HEADER_END) begin
      if (pending_status != ST_COMPLETE) begin
        packet_mode_next = MODE_DISCARD;
      end else if (pend) begin
        pending_status_next = ST_TOO_SHORT;
        packet_mode_next    = MODE_DISCARD;
      end else if (nal_type >= NAL_TYPE_MIN && nal_type <= NAL_TYPE_MAX) begin
        burst.has_start  = 1'b1;
        burst.has_data   = 1'b1;
        packet_mode_next = MODE_SINGLE;
      end else if (nal_type == FU_A_TYPE) begin
        indicator_bits_next    = b[7:5];
        fragment_position_next = FP_AWAIT;
        packet_mode_next       = MODE_FUA;
      end else begin
        pending_status_next = ST_UNSUPPORTED;
        packet_mode_next    = MODE_DISCARD;
      end
    end else if (packet_mode == MODE_SINGLE) begin
      burst.has_data = 1'b1;
      burst.done     = pend;
    end else if (packet_mode == MODE_FUA) begin
      if (fragment_position == FP_AWAIT) begin
        // FU header: bit 7 start, bit 6 end.
        if (b[7] && b[6]) begin
          pending_status_next = ST_START_END;
          packet_mode_next    = MODE_DISCARD;
        end else if (b[7]) begin
          if (pend) begin
            pending_status_next = ST_TOO_SHORT;
            packet_mode_next    = MODE_DISCARD;
          end else begin
            burst.has_start        = 1'b1;
            burst.has_data         = 1'b1;
            burst.data             = {indicator_bits, b[4:0]};
            assembly_active_next   = 1'b1;
            fragment_position_next = FP_START;
            pending_status_next    = ST_FRAGMENT;
          end
        end else if (!assembly_active) begin
          pending_status_next = ST_NO_START;
          packet_mode_next    = MODE_DISCARD;
        end else begin
          fragment_position_next = b[6] ? FP_END : FP_MIDDLE;
          pending_status_next    = b[6] ? ST_COMPLETE : ST_FRAGMENT;
        end
      end else begin
        burst.has_data = 1'b1;
        burst.done     = pend && (fragment_position == FP_END);
      end
    end

    if (byte_position < POS_SATURATE) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    if (pend) begin
      burst.has_status = 1'b1;
      if (byte_position < POS_HEADER_END) begin
        burst.code = ST_TOO_SHORT;
      end else begin
        burst.code = pending_status_next;
        if (packet_mode_next == MODE_SINGLE) begin
          assembly_active_next = 1'b0;
        end else if (packet_mode_next == MODE_FUA && fragment_position_next == FP_END) begin
          assembly_active_next = 1'b0;
        end
      end
      byte_position_next     = '0;
      packet_mode_next       = MODE_HEADER;
      pending_status_next    = ST_COMPLETE;
      fragment_position_next = FP_AWAIT;
    end
  end

  assign push = accept && (burst.has_start || burst.has_data || burst.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      packet_mode       <= MODE_HEADER;
      pending_status    <= ST_COMPLETE;
      assembly_active   <= 1'b0;
      indicator_bits    <= '0;
      fragment_position <= FP_AWAIT;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      packet_mode       <= packet_mode_next;
      pending_status    <= pending_status_next;
      assembly_active   <= assembly_active_next;
      indicator_bits    <= indicator_bits_next;
      fragment_position <= fragment_position_next;
    end
  end

  // A start code is always followed by its NAL header and never shares a beat
  // with a status item.
  a_start_has_header: assert property (@(posedge clk) disable iff (rst)
    push && burst.has_start |-> burst.has_data && !burst.has_status)
    else $error("start code burst without header byte");

  // An assembly only opens on a start fragment.
  a_assembly_opens_on_start: assert property (@(posedge clk) disable iff (rst)
    $rose(assembly_active) |-> $past(push && burst.has_start && packet_mode == MODE_FUA))
    else $error("assembly opened without a start fragment");

endmodule

// ===== rtl/core/rtph264_outq.sv =====
// ----------------------------------------------------------------------------
// rtph264_outq
// Burst queue that absorbs the per-byte bursts and unrolls them into single
// result beats.
// ----------------------------------------------------------------------------
module rtph264_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rtph264_pkg::burst_t    burst,
  output logic                   full,
  output logic                   res_valid,
  input  logic                   res_ready,
  output rtph264_pkg::res_item_t res
);
  import rtph264_pkg::*;

  burst_t          q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic [2:0]      cursor;

  burst_t     head;
  logic [2:0] phase;
  logic       last;
  logic       pop;
  logic       take;

  assign head      = q[rd_ptr];
  assign full      = (count == (Q_AW+1)'(Q_DEPTH));
  assign res_valid = (count != '0);
  assign take      = res_valid && res_ready;
  assign pop       = take && last;

  // The cursor says how far into the head burst we are; skip absent parts.
  always_comb begin
    if (cursor <= PH_SC_LAST && head.has_start) begin
      phase = cursor;
    end else if (cursor <= PH_DATA && head.has_data) begin
      phase = PH_DATA;
    end else begin
      phase = PH_STATUS;
    end

    case (phase)
      PH_STATUS: last = 1'b1;
      PH_DATA:   last = !head.has_status;
      PH_SC_LAST: last = !head.has_data && !head.has_status;
      default:   last = 1'b0;
    endcase

    res             = '0;
    res.run_last    = last;
    case (phase)
      PH_STATUS: begin
        res.item_kind   = 1'b1;
        res.status_code = head.code;
      end
      PH_DATA: begin
        res.nal_byte = head.data;
        res.nal_done = head.done;
      end
      PH_SC_LAST: res.nal_byte = START_CODE_HI;
      default:    res.nal_byte = START_CODE_LO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      cursor <= PH_SC_FIRST;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
        cursor <= PH_SC_FIRST;
      end else if (take) begin
        cursor <= phase + 3'd1;
      end
      if (push && !pop) begin
        count <= count + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_AW+1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("burst queue overflow");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("burst written into a full queue");

  a_cursor_restarts: assert property (@(posedge clk) disable iff (rst)
    pop |=> cursor == PH_SC_FIRST)
    else $error("cursor not reset after last beat of a burst");

endmodule

// ===== rtl/core/rtp_h264_nal_reassembler.sv =====
// ----------------------------------------------------------------------------
// rtp_h264_nal_reassembler
// RTP H.264 depacketizer: header check, single NAL pass-through and FU-A
// reassembly into Annex-B byte stream, with one status beat per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle while pkt_ready is high, which
// drops only while the queue is full, and works it in a single pass: the
// parser turns each accepted byte into a burst of zero to five result beats
// (start code 00 00 00 01 plus NAL header on a new NAL, one data byte, or a
// status beat at packet end), which enters an 8-entry burst queue. The output
// side unrolls it at one result beat per cycle while res_ready is high, so a
// result appears in the cycle after its byte at the earliest; with one result
// per byte the queue drains, and each start burst delays later results. The
// user must write the payload type register (address 0, reset 96) over the
// APB port only while no packet is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module rtp_h264_nal_reassembler (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pkt_valid,
  output logic                   pkt_ready,
  input  rtph264_pkg::pkt_item_t pkt,
  output logic                   res_valid,
  input  logic                   res_ready,
  output rtph264_pkg::res_item_t res,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import rtph264_pkg::*;

  logic [6:0] expected_pt;
  logic       accept;
  logic       push;
  logic       full;
  burst_t     burst;

  assign pready    = 1'b1;
  assign pkt_ready = !full;
  assign accept    = pkt_valid && pkt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_pt <= PAYLOAD_TYPE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_PAYLOAD_TYPE) begin
      expected_pt <= pwdata[6:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PAYLOAD_TYPE: prdata = {25'd0, expected_pt};
      default:          prdata = '0;
    endcase
  end

  rtph264_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pkt         (pkt),
    .expected_pt (expected_pt),
    .push        (push),
    .burst       (burst)
  );

  rtph264_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .burst     (burst),
    .full      (full),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RTP H.264 NAL reassembler. Packet bytes go in on
// a valid/ready channel, and a local depacketizer predicts the Annex-B beats
// and per-packet status. Every result beat is compared field by field. A
// directed table covers the header, type and fragment corner cases. Random
// packets follow, mostly FU-A and single NAL sequences, under several payload
// type settings, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import rtph264_pkg::*;

  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [2:0] PT_ADDR     = {2'b00, REG_PAYLOAD_TYPE} << 2;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 120;
  localparam int PHASE_BYTES   = 16;
  localparam int MAX_REPORTS   = 50;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] nal_hdr;
    logic [7:0] fu_hdr;
    logic [5:0] len;
    logic       typed;
    status_t    code;
  } dir_row_t;

  typedef struct packed {
    logic    typed;
    status_t code;
  } status_pin_t;

  localparam int N_DIRECTED = 34;
  // Bytes 0, 1, 12 and 13 of each packet; all other bytes are random.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h80, 8'h60, 8'h00, 8'h00, 6'd1,  1'b1, ST_TOO_SHORT},
    '{8'hBF, 8'hE0, 8'h00, 8'h00, 6'd12, 1'b1, ST_TOO_SHORT},
    '{8'hFF, 8'h60, 8'h00, 8'h00, 6'd12, 1'b1, ST_TOO_SHORT},
    '{8'h80, 8'h60, 8'h41, 8'h00, 6'd13, 1'b1, ST_TOO_SHORT},
    '{8'h40, 8'h60, 8'h41, 8'h00, 6'd13, 1'b1, ST_BAD_VERSION},
    '{8'h00, 8'h7F, 8'h41, 8'h00, 6'd14, 1'b1, ST_BAD_VERSION},
    '{8'h80, 8'h61, 8'h41, 8'h00, 6'd14, 1'b1, ST_BAD_TYPE},
    '{8'h80, 8'hFF, 8'h41, 8'h00, 6'd14, 1'b1, ST_BAD_TYPE},
    '{8'h80, 8'hE0, 8'h65, 8'h00, 6'd16, 1'b0, ST_COMPLETE},
    '{8'h80, 8'h60, 8'hF7, 8'h00, 6'd14, 1'b0, ST_COMPLETE},
    '{8'h80, 8'h60, 8'h00, 8'h00, 6'd14, 1'b1, ST_UNSUPPORTED},
    '{8'h80, 8'h60, 8'h18, 8'h00, 6'd14, 1'b1, ST_UNSUPPORTED},
    '{8'h80, 8'h60, 8'h1B, 8'h00, 6'd14, 1'b1, ST_UNSUPPORTED},
    '{8'h80, 8'h60, 8'h1D, 8'h00, 6'd14, 1'b1, ST_UNSUPPORTED},
    '{8'h80, 8'h60, 8'hFF, 8'h00, 6'd14, 1'b1, ST_UNSUPPORTED},
    '{8'h80, 8'h60, 8'h7C, 8'h00, 6'd13, 1'b1, ST_TOO_SHORT},
    '{8'h80, 8'h60, 8'h7C, 8'h05, 6'd15, 1'b1, ST_NO_START},
    '{8'h80, 8'h60, 8'h7C, 8'h45, 6'd14, 1'b1, ST_NO_START},
    '{8'h80, 8'h60, 8'h7C, 8'hC5, 6'd15, 1'b1, ST_START_END},
    '{8'h80, 8'h60, 8'h7C, 8'h85, 6'd14, 1'b1, ST_TOO_SHORT},
    '{8'h80, 8'h60, 8'h7C, 8'h85, 6'd16, 1'b1, ST_FRAGMENT},
    '{8'h80, 8'h60, 8'h7C, 8'h05, 6'd15, 1'b1, ST_FRAGMENT},
    '{8'h80, 8'h60, 8'h7C, 8'h45, 6'd16, 1'b1, ST_COMPLETE},
    '{8'h80, 8'h60, 8'hFC, 8'h9F, 6'd15, 1'b1, ST_FRAGMENT},
    '{8'h80, 8'h60, 8'h1C, 8'h81, 6'd15, 1'b1, ST_FRAGMENT},
    '{8'h80, 8'h60, 8'h7C, 8'h5F, 6'd14, 1'b1, ST_COMPLETE},
    '{8'h80, 8'h60, 8'h7C, 8'h41, 6'd15, 1'b1, ST_NO_START},
    '{8'h80, 8'h60, 8'h7C, 8'h85, 6'd15, 1'b1, ST_FRAGMENT},
    '{8'h80, 8'h60, 8'h41, 8'h00, 6'd20, 1'b0, ST_COMPLETE},
    '{8'h80, 8'h60, 8'h7C, 8'h45, 6'd15, 1'b1, ST_NO_START},
    '{8'h80, 8'h60, 8'h7C, 8'h85, 6'd15, 1'b1, ST_FRAGMENT},
    '{8'h80, 8'h60, 8'h7C, 8'hA5, 6'd15, 1'b1, ST_FRAGMENT},
    '{8'h80, 8'h60, 8'h7C, 8'hE5, 6'd15, 1'b1, ST_START_END},
    '{8'h80, 8'h60, 8'h7C, 8'h65, 6'd14, 1'b1, ST_COMPLETE}
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        pkt_valid = 1'b0;
  logic        pkt_ready;
  pkt_item_t   pkt       = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_item_t   res;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the depacketizer state.
  logic [6:0] pt_cfg    = PAYLOAD_TYPE_RESET;
  logic [3:0] hdr_pos   = '0;
  mode_t      pkt_mode  = MODE_HEADER;
  status_t    pend_code = ST_COMPLETE;
  logic       fu_open   = 1'b0;
  logic [2:0] fu_nri    = '0;
  logic [1:0] fu_pos    = FP_AWAIT;

  res_item_t   annexb_q[$];
  status_pin_t status_pins[$];

  int unsigned mismatches  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;
  logic        no_idle     = 1'b0;
  logic        hold_req    = 1'b0;
  logic        holding     = 1'b0;

  rtp_h264_nal_reassembler dut (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** rtp_h264_nal_reassembler: FAILED **");
      $finish;
    end
  end

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic res_item_t nal_beat(input logic [7:0] b, input logic done);
    res_item_t r;
    r           = '0;
    r.item_kind = KIND_DATA;
    r.nal_byte  = b;
    r.nal_done  = done;
    return r;
  endfunction

  // Works out the result beats of one accepted packet byte and queues them.
  function automatic void depacketize(input logic [7:0] b, input logic last);
    res_item_t  burst [5];
    int         n;
    int         k;
    logic [3:0] at;
    logic [4:0] t;
    status_t    code;
    n  = 0;
    at = hdr_pos;
    t  = b[4:0];
    if (at < POS_HEADER_END) begin
      if (at == 4'd0 && b[7:6] != RTP_VERSION) pend_code = ST_BAD_VERSION;
      if (at == 4'd1 && pend_code == ST_COMPLETE && b[6:0] != pt_cfg)
        pend_code = ST_BAD_TYPE;
    end else if (at == POS_HEADER_END) begin
      if (pend_code != ST_COMPLETE) begin
        pkt_mode = MODE_DISCARD;
      end else if (last) begin
        pend_code = ST_TOO_SHORT;
        pkt_mode  = MODE_DISCARD;
      end else if (t >= NAL_TYPE_MIN && t <= NAL_TYPE_MAX) begin
        for (k = 0; k < 4; k++) begin
          burst[n] = nal_beat(k == 3 ? START_CODE_HI : START_CODE_LO, 1'b0);
          n++;
        end
        burst[n] = nal_beat(b, 1'b0);
        n++;
        pkt_mode = MODE_SINGLE;
      end else if (t == FU_A_TYPE) begin
        fu_nri   = b[7:5];
        fu_pos   = FP_AWAIT;
        pkt_mode = MODE_FUA;
      end else begin
        pend_code = ST_UNSUPPORTED;
        pkt_mode  = MODE_DISCARD;
      end
    end else if (pkt_mode == MODE_SINGLE) begin
      burst[n] = nal_beat(b, last);
      n++;
    end else if (pkt_mode == MODE_FUA) begin
      if (fu_pos == FP_AWAIT) begin
        // FU header: bit 7 start, bit 6 end, low five bits the NAL type.
        if (b[7] && b[6]) begin
          pend_code = ST_START_END;
          pkt_mode  = MODE_DISCARD;
        end else if (b[7]) begin
          if (last) begin
            pend_code = ST_TOO_SHORT;
            pkt_mode  = MODE_DISCARD;
          end else begin
            for (k = 0; k < 4; k++) begin
              burst[n] = nal_beat(k == 3 ? START_CODE_HI : START_CODE_LO, 1'b0);
              n++;
            end
            burst[n] = nal_beat({fu_nri, b[4:0]}, 1'b0);
            n++;
            fu_open   = 1'b1;
            fu_pos    = FP_START;
            pend_code = ST_FRAGMENT;
          end
        end else if (!fu_open) begin
          pend_code = ST_NO_START;
          pkt_mode  = MODE_DISCARD;
        end else begin
          fu_pos    = b[6] ? FP_END : FP_MIDDLE;
          pend_code = b[6] ? ST_COMPLETE : ST_FRAGMENT;
        end
      end else begin
        burst[n] = nal_beat(b, last && fu_pos == FP_END);
        n++;
      end
    end
    if (hdr_pos < POS_SATURATE) hdr_pos = hdr_pos + 4'd1;
    if (last) begin
      code = pend_code;
      if (at < POS_HEADER_END) code = ST_TOO_SHORT;
      else if (pkt_mode == MODE_SINGLE) fu_open = 1'b0;
      else if (pkt_mode == MODE_FUA && fu_pos == FP_END) fu_open = 1'b0;
      burst[n]             = '0;
      burst[n].item_kind   = KIND_STATUS;
      burst[n].status_code = code;
      n++;
      hdr_pos   = '0;
      pkt_mode  = MODE_HEADER;
      pend_code = ST_COMPLETE;
      fu_pos    = FP_AWAIT;
    end
    if (n > 0) burst[n-1].run_last = 1'b1;
    for (k = 0; k < n; k++) annexb_q.push_back(burst[k]);
  endfunction

  task automatic check_beat(input res_item_t got);
    res_item_t   want;
    status_pin_t pin;
    if (annexb_q.size() == 0) begin
      log_mismatch($sformatf("beat with nothing expected: kind %0d byte %02h code %0d",
                             got.item_kind, got.nal_byte, got.status_code));
      return;
    end
    want = annexb_q.pop_front();
    if (got.item_kind !== want.item_kind)
      log_mismatch($sformatf("item_kind %0d, expected %0d", got.item_kind, want.item_kind));
    if (got.nal_byte !== want.nal_byte)
      log_mismatch($sformatf("nal_byte %02h, expected %02h", got.nal_byte, want.nal_byte));
    if (got.nal_done !== want.nal_done)
      log_mismatch($sformatf("nal_done %0d, expected %0d", got.nal_done, want.nal_done));
    if (got.status_code !== want.status_code)
      log_mismatch($sformatf("status_code %0d, expected %0d",
                             got.status_code, want.status_code));
    if (got.run_last !== want.run_last)
      log_mismatch($sformatf("run_last %0d, expected %0d", got.run_last, want.run_last));
    // Status beats pair one to one with packets, so the table value applies here.
    if (want.item_kind == KIND_STATUS && status_pins.size() != 0) begin
      pin = status_pins.pop_front();
      if (pin.typed && got.status_code !== pin.code)
        log_mismatch($sformatf("status_code %0d, table says %0d", got.status_code, pin.code));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (pkt_valid && pkt_ready) depacketize(pkt.packet_byte, pkt.packet_end);
      if (res_valid && res_ready) check_beat(res);
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned pay_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(25, 40);
    if (r == 1) return 13;
    return $urandom_range(14, 22);
  endfunction

  // Output side: random runs of ready, random stalls, and one long hold-off
  // on request so that the burst queue fills and the input stalls.
  initial begin
    int unsigned run;
    int unsigned gap;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
      end else begin
        run = $urandom_range(1, 30);
        res_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = idle_len();
        if (gap != 0) begin
          res_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last, input logic quiet);
    int unsigned gap;
    pkt_valid <= 1'b1;
    pkt       <= {b, last};
    @(posedge clk);
    while (pkt_ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] nal_hdr, input logic [7:0] fu_hdr,
                             input int unsigned len, input logic typed,
                             input status_t code);
    int unsigned i;
    logic [7:0]  b;
    logic        quiet;
    status_pin_t pin;
    quiet     = no_idle || ($urandom_range(0, 3) == 0);
    pin.typed = typed;
    pin.code  = code;
    status_pins.push_back(pin);
    for (i = 0; i < len; i++) begin
      case (i)
        0:                b = b0;
        1:                b = b1;
        HEADER_BYTES:     b = nal_hdr;
        HEADER_BYTES + 1: b = fu_hdr;
        default:          b = 8'($urandom);
      endcase
      send_beat(b, i == len - 1, quiet);
    end
  endtask

  task automatic send_random_packet();
    int unsigned pick;
    int unsigned n_mid;
    int unsigned k;
    int unsigned t;
    logic [1:0]  ver;
    logic [7:0]  v1;
    v1   = {1'($urandom), pt_cfg};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // FU-A sequence: start, zero to two middles, end.
      send_packet({RTP_VERSION, 6'($urandom)}, v1, {3'($urandom), FU_A_TYPE},
                  {2'b10, 6'($urandom)}, pay_len(), 1'b0, ST_COMPLETE);
      n_mid = $urandom_range(0, 2);
      for (k = 0; k < n_mid; k++)
        send_packet({RTP_VERSION, 6'($urandom)}, v1, {3'($urandom), FU_A_TYPE},
                    {2'b00, 6'($urandom)}, pay_len(), 1'b0, ST_COMPLETE);
      send_packet({RTP_VERSION, 6'($urandom)}, v1, {3'($urandom), FU_A_TYPE},
                  {2'b01, 6'($urandom)}, ($urandom_range(0, 4) == 0) ? 14 : pay_len(),
                  1'b0, ST_COMPLETE);
    end else if (pick < 65) begin
      send_packet({RTP_VERSION, 6'($urandom)}, v1,
                  {3'($urandom), 5'($urandom_range(1, 23))}, 8'($urandom), pay_len(),
                  1'b0, ST_COMPLETE);
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          ver = 2'($urandom_range(0, 2));
          if (ver == RTP_VERSION) ver = 2'd3;
          send_packet({ver, 6'($urandom)}, v1, 8'($urandom), 8'($urandom), pay_len(),
                      1'b0, ST_COMPLETE);
        end
        1: send_packet({RTP_VERSION, 6'($urandom)},
                       {1'($urandom), pt_cfg + 7'($urandom_range(1, 127))},
                       8'($urandom), 8'($urandom), pay_len(), 1'b0, ST_COMPLETE);
        2: begin
          // Types 0, 24 to 27 and 29 to 31.
          t = $urandom_range(0, 7);
          t = (t == 0) ? 0 : (t < 5) ? 23 + t : 24 + t;
          send_packet({RTP_VERSION, 6'($urandom)}, v1, {3'($urandom), 5'(t)},
                      8'($urandom), pay_len(), 1'b0, ST_COMPLETE);
        end
        3: send_packet({RTP_VERSION, 6'($urandom)}, v1, {3'($urandom), FU_A_TYPE},
                       8'($urandom), pay_len(), 1'b0, ST_COMPLETE);
        default: send_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             $urandom_range(1, 20), 1'b0, ST_COMPLETE);
      endcase
    end
  endtask

  // Stops the input and lets every expected beat drain out.
  task automatic wait_idle();
    pkt_valid <= 1'b0;
    @(posedge clk);
    while (annexb_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_payload_type(input logic [6:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata[6:0] !== want)
      log_mismatch($sformatf("payload type reads %0d, expected %0d", prdata[6:0], want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_payload_type(input logic [6:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    pt_cfg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    read_payload_type(value);
  endtask

  initial begin
    int unsigned k;
    int unsigned phase_end;
    logic [6:0]  pt_plan [4];
    pt_plan[0] = 7'd127;
    pt_plan[1] = 7'd0;
    pt_plan[2] = 7'($urandom_range(1, 126));
    pt_plan[3] = PAYLOAD_TYPE_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_payload_type(PAYLOAD_TYPE_RESET);

    for (k = 0; k < N_DIRECTED; k++)
      send_packet(DIRECTED[k].b0, DIRECTED[k].b1, DIRECTED[k].nal_hdr, DIRECTED[k].fu_hdr,
                  DIRECTED[k].len, DIRECTED[k].typed, DIRECTED[k].code);

    for (k = 0; k < 4; k++) begin
      write_payload_type(pt_plan[k]);
      if (k == 0) begin
        // Keep offering beats with no idling while the output is held off.
        hold_req = 1'b1;
        while (!holding) @(posedge clk);
        no_idle = 1'b1;
        while (holding) send_random_packet();
        no_idle = 1'b0;
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_random_packet();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("** rtp_h264_nal_reassembler: PASSED **");
    end else begin
      $display("** rtp_h264_nal_reassembler: FAILED **");
    end
    $finish;
  end

endmodule
